@@ rtl/lfu_pkg.sv @@
// lfu_pkg: shared constants and types for the LFU cache table.
// Used by lfu_cache_table and tb_lfu_cache_table; no dependencies.
`default_nettype none
package lfu_pkg;
  localparam int ENTRIES    = 16;
  localparam int COUNT_BITS = 16;
  localparam int IDX_W      = $clog2(ENTRIES);
  localparam int OCC_W      = $clog2(ENTRIES + 1);
  localparam int KEY_W      = 32;
  localparam int VAL_W      = 32;
  localparam int CAP_W      = 5;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_PUT = 1'b1;
  localparam int ENT_W = KEY_W + VAL_W + COUNT_BITS + IDX_W;

  // one table entry as stored in the memory
  typedef struct packed {
    logic [KEY_W-1:0]      key;
    logic [VAL_W-1:0]      data;
    logic [COUNT_BITS-1:0] cnt;
    logic [IDX_W-1:0]      age;
  } entry_t;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_SCAN  = 6'b000010,
    ST_DEC   = 6'b000100,
    ST_AGE   = 6'b001000,
    ST_WRITE = 6'b010000,
    ST_DONE  = 6'b100000
  } state_t;
endpackage
`default_nettype wire

@@ rtl/lfu_ram.sv @@
// lfu_ram: generic single-port-write, one-read RAM with registered read.
// No dependencies.
`default_nettype none
module lfu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ rtl/lfu_cache_table.sv @@
// lfu_cache_table: LFU key/value cache with LRU tie break.
// Depends on lfu_pkg and lfu_ram.
`default_nettype none
// Usage:
//   Pulse start with in_cmd (0 get, 1 put), in_lookup_key, in_write_value
//   while busy is low. One result follows, shown for one cycle with
//   out_valid high: hit, read_value, evicted, evicted_key.
//   cfg_we/cfg_wdata writes the capacity (0 acts as 1, above 16 as 16).
// Timing:
//   Key, data, count and age live in one RAM read one entry per cycle.
//   Each pass reads every entry of the table in turn. A get miss needs only
//   the scan pass; a hit or a plain insert adds one age pass and a write
//   step; an evicting put adds a further age pass before them. busy stays
//   high from start until the result cycle has ended, so a new item is
//   only taken once the last result has been shown.
// Reset:
//   Synchronous active-low rst_n clears all valid bits, occupancy and the
//   controller; capacity returns to 16. No clearing pass is needed, as
//   entry fields are only used under their valid bit.
//   The receiver cannot stall; each result is taken in its strobe cycle.
module lfu_cache_table (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic                      in_cmd,
  input  wire logic [lfu_pkg::KEY_W-1:0] in_lookup_key,
  input  wire logic [lfu_pkg::VAL_W-1:0] in_write_value,
  output logic                           out_valid,
  output logic                           out_hit,
  output logic [lfu_pkg::VAL_W-1:0]      out_read_value,
  output logic                           out_evicted,
  output logic [lfu_pkg::KEY_W-1:0]      out_evicted_key,
  input  wire logic                      cfg_we,
  input  wire logic [lfu_pkg::CAP_W-1:0] cfg_wdata
);
  localparam int IW = lfu_pkg::IDX_W;
  localparam int PW = IW + 1;

  lfu_pkg::state_t state_r, state_nxt;
  logic [lfu_pkg::CAP_W-1:0] cap_r;
  logic [lfu_pkg::ENTRIES-1:0] valid_r, valid_nxt;
  logic [lfu_pkg::OCC_W-1:0] occ_r, occ_nxt;
  logic cmd_r;
  logic [lfu_pkg::KEY_W-1:0] key_r;
  logic [lfu_pkg::VAL_W-1:0] val_r;
  // pass counter: read address runs one ahead of returned data
  logic [PW-1:0] cnt_r, cnt_nxt;
  logic [IW-1:0] didx_r, didx_nxt;   // index of the data now on rdata
  logic dv_r, dv_nxt;
  // scan results
  logic found_r, found_nxt;
  logic [IW-1:0] fidx_r, fidx_nxt;
  lfu_pkg::entry_t fent_r, fent_nxt;
  logic vic_ok_r, vic_ok_nxt;
  logic [IW-1:0] vidx_r, vidx_nxt;
  lfu_pkg::entry_t vent_r, vent_nxt;
  logic free_ok_r, free_ok_nxt;
  logic [IW-1:0] free_r, free_nxt;
  // result registers
  logic ov_r, ov_nxt, oh_r, oh_nxt, oe_r, oe_nxt;
  logic [lfu_pkg::VAL_W-1:0] orv_r, orv_nxt;
  logic [lfu_pkg::KEY_W-1:0] oek_r, oek_nxt;
  // target slot and its age threshold for the age pass
  logic [IW-1:0] tidx_r, tidx_nxt;
  logic [IW-1:0] tage_r, tage_nxt;
  logic tmode_r, tmode_nxt;   // 1: touch hit entry, 0: insert new
  // item accepted this cycle
  logic in_acc;

  // ram
  logic ram_we;
  logic [IW-1:0] ram_waddr, ram_raddr;
  lfu_pkg::entry_t ram_wdata, rd;
  logic [lfu_pkg::ENT_W-1:0] rd_bits;

  lfu_ram #(.WIDTH(lfu_pkg::ENT_W), .DEPTH(lfu_pkg::ENTRIES)) u_ram (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(rd_bits)
  );
  assign rd = lfu_pkg::entry_t'(rd_bits);

  // effective capacity
  logic [lfu_pkg::OCC_W-1:0] cap_eff;
  always_comb begin
    priority if (cap_r == '0) cap_eff = lfu_pkg::OCC_W'(1);
    else if (32'(cap_r) > lfu_pkg::ENTRIES) cap_eff = lfu_pkg::OCC_W'(lfu_pkg::ENTRIES);
    else cap_eff = lfu_pkg::OCC_W'(cap_r);
  end

  assign ram_raddr = cnt_r[IW-1:0];
  assign in_acc = start && !busy;

  // controller and read-modify-write datapath
  always_comb begin
    state_nxt = state_r;  valid_nxt = valid_r;  occ_nxt = occ_r;
    cnt_nxt = cnt_r;      didx_nxt = didx_r;    dv_nxt = 1'b0;
    found_nxt = found_r;  fidx_nxt = fidx_r;    fent_nxt = fent_r;
    vic_ok_nxt = vic_ok_r; vidx_nxt = vidx_r;   vent_nxt = vent_r;
    free_ok_nxt = free_ok_r; free_nxt = free_r;
    ov_nxt = 1'b0; oh_nxt = oh_r; oe_nxt = oe_r; orv_nxt = orv_r; oek_nxt = oek_r;
    tidx_nxt = tidx_r; tage_nxt = tage_r; tmode_nxt = tmode_r;
    ram_we = 1'b0; ram_waddr = didx_r; ram_wdata = rd;

    unique case (state_r)
      lfu_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_nxt = lfu_pkg::ST_SCAN;
          cnt_nxt = '0;
          found_nxt = 1'b0; vic_ok_nxt = 1'b0; free_ok_nxt = 1'b0;
          oh_nxt = 1'b0; oe_nxt = 1'b0; orv_nxt = '0; oek_nxt = '0;
        end
      end
      // one entry per cycle: key match, victim, lowest free slot
      lfu_pkg::ST_SCAN: begin
        if (!dv_r || cnt_r != PW'(lfu_pkg::ENTRIES)) begin
          cnt_nxt = cnt_r + 1'b1;
          didx_nxt = cnt_r[IW-1:0];
          dv_nxt = 1'b1;
        end
        if (dv_r) begin
          if (valid_r[didx_r]) begin
            if (!found_r && rd.key == key_r) begin
              found_nxt = 1'b1; fidx_nxt = didx_r; fent_nxt = rd;
            end
            if (!vic_ok_r || rd.cnt < vent_r.cnt ||
                (rd.cnt == vent_r.cnt && rd.age > vent_r.age)) begin
              vic_ok_nxt = 1'b1; vidx_nxt = didx_r; vent_nxt = rd;
            end
          end else if (!free_ok_r) begin
            free_ok_nxt = 1'b1; free_nxt = didx_r;
          end
          if (didx_r == IW'(lfu_pkg::ENTRIES - 1)) begin
            cnt_nxt = '0;
            dv_nxt = 1'b0;
            priority if (found_nxt) begin
              oh_nxt = 1'b1;
              if (cmd_r == lfu_pkg::CMD_GET) orv_nxt = fent_nxt.data;
              tidx_nxt = fidx_nxt; tage_nxt = fent_nxt.age; tmode_nxt = 1'b1;
              state_nxt = lfu_pkg::ST_AGE;
            end else if (cmd_r == lfu_pkg::CMD_GET) begin
              state_nxt = lfu_pkg::ST_DONE;
            end else if (occ_r >= cap_eff && vic_ok_nxt) begin
              oe_nxt = 1'b1; oek_nxt = vent_nxt.key;
              valid_nxt[vidx_nxt] = 1'b0;
              occ_nxt = occ_r - 1'b1;
              tidx_nxt = vidx_nxt; tage_nxt = vent_nxt.age; tmode_nxt = 1'b0;
              state_nxt = lfu_pkg::ST_DEC;
            end else if (free_ok_nxt) begin
              tidx_nxt = free_nxt; tmode_nxt = 1'b0;
              state_nxt = lfu_pkg::ST_AGE;
            end else begin
              state_nxt = lfu_pkg::ST_DONE;
            end
          end
        end
      end
      // after eviction: older entries step one age younger
      lfu_pkg::ST_DEC: begin
        if (!dv_r || cnt_r != PW'(lfu_pkg::ENTRIES)) begin
          cnt_nxt = cnt_r + 1'b1;
          didx_nxt = cnt_r[IW-1:0];
          dv_nxt = 1'b1;
        end
        if (dv_r) begin
          if (valid_r[didx_r] && rd.age > tage_r) begin
            ram_we = 1'b1; ram_wdata.age = rd.age - 1'b1;
          end
          if (didx_r == IW'(lfu_pkg::ENTRIES - 1)) begin
            cnt_nxt = '0; dv_nxt = 1'b0;
            state_nxt = lfu_pkg::ST_AGE;
          end
        end
      end
      // age pass: touch ages younger entries, insert ages all
      lfu_pkg::ST_AGE: begin
        if (!dv_r || cnt_r != PW'(lfu_pkg::ENTRIES)) begin
          cnt_nxt = cnt_r + 1'b1;
          didx_nxt = cnt_r[IW-1:0];
          dv_nxt = 1'b1;
        end
        if (dv_r) begin
          if (valid_r[didx_r] && didx_r != tidx_r &&
              (!tmode_r || rd.age < tage_r)) begin
            ram_we = 1'b1; ram_wdata.age = rd.age + 1'b1;
          end
          if (didx_r == IW'(lfu_pkg::ENTRIES - 1)) begin
            cnt_nxt = '0; dv_nxt = 1'b0;
            state_nxt = lfu_pkg::ST_WRITE;
          end
        end
      end
      // write the target entry
      lfu_pkg::ST_WRITE: begin
        ram_we = 1'b1; ram_waddr = tidx_r;
        ram_wdata.age = '0;
        if (tmode_r) begin
          ram_wdata.key = fent_r.key;
          ram_wdata.data = (cmd_r == lfu_pkg::CMD_PUT) ? val_r : fent_r.data;
          ram_wdata.cnt = (fent_r.cnt == lfu_pkg::COUNT_MAX) ? fent_r.cnt
                                                             : fent_r.cnt + 1'b1;
        end else begin
          ram_wdata.key = key_r; ram_wdata.data = val_r;
          ram_wdata.cnt = lfu_pkg::COUNT_BITS'(1);
          valid_nxt[tidx_r] = 1'b1;
          occ_nxt = occ_r + 1'b1;
        end
        state_nxt = lfu_pkg::ST_DONE;
      end
      lfu_pkg::ST_DONE: begin
        ov_nxt = 1'b1;
        state_nxt = lfu_pkg::ST_IDLE;
      end
      default: state_nxt = lfu_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lfu_pkg::ST_IDLE;
      cap_r <= lfu_pkg::CAP_W'(16);
      valid_r <= '0;
      occ_r <= '0;
      cnt_r <= '0;
      dv_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) cap_r <= cfg_wdata;
      valid_r <= valid_nxt;
      occ_r <= occ_nxt;
      cnt_r <= cnt_nxt;
      dv_r <= dv_nxt;
      ov_r <= ov_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r <= in_cmd; key_r <= in_lookup_key; val_r <= in_write_value;
    end
    didx_r <= didx_nxt;
    found_r <= found_nxt; fidx_r <= fidx_nxt; fent_r <= fent_nxt;
    vic_ok_r <= vic_ok_nxt; vidx_r <= vidx_nxt; vent_r <= vent_nxt;
    free_ok_r <= free_ok_nxt; free_r <= free_nxt;
    oh_r <= oh_nxt; oe_r <= oe_nxt; orv_r <= orv_nxt; oek_r <= oek_nxt;
    tidx_r <= tidx_nxt; tage_r <= tage_nxt; tmode_r <= tmode_nxt;
  end

  assign busy = (state_r != lfu_pkg::ST_IDLE) || ov_r;
  assign out_valid = ov_r;
  assign out_hit = oh_r;
  assign out_read_value = orv_r;
  assign out_evicted = oe_r;
  assign out_evicted_key = oek_r;

  // checks
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(occ_r) <= lfu_pkg::ENTRIES && $countones(valid_r) == 32'(occ_r))
    else $error("occupancy differs from valid count");
  a_hit_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_hit && out_evicted))
    else $error("hit and eviction together");
  a_result_once: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");
endmodule
`default_nettype wire

@@ dv/tb_lfu_cache_table.sv @@
// tb_lfu_cache_table: self-checking testbench for the LFU cache table.
// Drives get/put items with random sender gaps and predicts each result.
// Depends on lfu_pkg and the lfu_cache_table RTL.
module tb_lfu_cache_table;

  typedef struct packed {
    logic                      hit;
    logic [lfu_pkg::VAL_W-1:0] read_value;
    logic                      evicted;
    logic [lfu_pkg::KEY_W-1:0] evicted_key;
  } lookup_result_t;

  logic                      clk;
  logic                      rst_n;
  logic                      start;
  logic                      busy;
  logic                      in_cmd;
  logic [lfu_pkg::KEY_W-1:0] in_lookup_key;
  logic [lfu_pkg::VAL_W-1:0] in_write_value;
  logic                      out_valid;
  logic                      out_hit;
  logic [lfu_pkg::VAL_W-1:0] out_read_value;
  logic                      out_evicted;
  logic [lfu_pkg::KEY_W-1:0] out_evicted_key;
  logic                      cfg_we;
  logic [lfu_pkg::CAP_W-1:0] cfg_wdata;

  lfu_cache_table u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_cmd         (in_cmd),
    .in_lookup_key  (in_lookup_key),
    .in_write_value (in_write_value),
    .out_valid      (out_valid),
    .out_hit        (out_hit),
    .out_read_value (out_read_value),
    .out_evicted    (out_evicted),
    .out_evicted_key(out_evicted_key),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata)
  );

  // shadow copy of the cache
  logic                           sh_valid [lfu_pkg::ENTRIES];
  logic [lfu_pkg::KEY_W-1:0]      sh_key   [lfu_pkg::ENTRIES];
  logic [lfu_pkg::VAL_W-1:0]      sh_data  [lfu_pkg::ENTRIES];
  logic [lfu_pkg::COUNT_BITS-1:0] sh_count [lfu_pkg::ENTRIES];
  int                             sh_age   [lfu_pkg::ENTRIES];
  int                             sh_occ;
  logic [lfu_pkg::CAP_W-1:0]      sh_cap;

  lookup_result_t pending_results[$];
  logic [lfu_pkg::KEY_W-1:0] key_pool[$];
  int errors;
  int items_sent;
  int results_seen;
  int hits_seen;
  int evictions_seen;
  int burst_left;

  // clock
  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // mark slot s most recent and bump its count
  function automatic void shadow_touch(int s);
    for (int i = 0; i < lfu_pkg::ENTRIES; i++) begin
      if (sh_valid[i] && sh_age[i] < sh_age[s]) sh_age[i]++;
    end
    sh_age[s] = 0;
    if (sh_count[s] != lfu_pkg::COUNT_MAX) sh_count[s]++;
  endfunction

  // expected result of one get/put, updating the shadow cache
  function automatic lookup_result_t cache_access(logic cmd,
                                                  logic [lfu_pkg::KEY_W-1:0] key,
                                                  logic [lfu_pkg::VAL_W-1:0] val);
    lookup_result_t r;
    int cap;
    int found;
    int slot;
    int a;
    r = '0;
    found = -1;
    slot = -1;
    cap = (sh_cap < 1) ? 1 : (sh_cap > lfu_pkg::ENTRIES) ? lfu_pkg::ENTRIES : int'(sh_cap);
    for (int i = 0; i < lfu_pkg::ENTRIES; i++) begin
      if (found < 0 && sh_valid[i] && sh_key[i] == key) found = i;
    end
    if (found >= 0) begin
      r.hit = 1'b1;
      if (cmd == lfu_pkg::CMD_PUT) sh_data[found] = val;
      else r.read_value = sh_data[found];
      shadow_touch(found);
      return r;
    end
    if (cmd == lfu_pkg::CMD_GET) return r;
    // full: evict lowest count, oldest among equals
    if (sh_occ >= cap) begin
      for (int i = 0; i < lfu_pkg::ENTRIES; i++) begin
        if (sh_valid[i] && (slot < 0 || sh_count[i] < sh_count[slot] ||
            (sh_count[i] == sh_count[slot] && sh_age[i] > sh_age[slot])))
          slot = i;
      end
      if (slot >= 0) begin
        a = sh_age[slot];
        r.evicted = 1'b1;
        r.evicted_key = sh_key[slot];
        sh_valid[slot] = 1'b0;
        sh_occ--;
        for (int i = 0; i < lfu_pkg::ENTRIES; i++) begin
          if (sh_valid[i] && sh_age[i] > a) sh_age[i]--;
        end
      end
    end
    if (slot < 0) begin
      for (int i = lfu_pkg::ENTRIES - 1; i >= 0; i--) begin
        if (!sh_valid[i]) slot = i;
      end
    end
    if (slot < 0) return r;
    for (int i = 0; i < lfu_pkg::ENTRIES; i++) begin
      if (sh_valid[i]) sh_age[i]++;
    end
    sh_valid[slot] = 1'b1;
    sh_key[slot]   = key;
    sh_data[slot]  = val;
    sh_count[slot] = 1;
    sh_age[slot]   = 0;
    sh_occ++;
    return r;
  endfunction

  // present one item and hold it until the block takes it
  task automatic send_item(logic cmd, logic [lfu_pkg::KEY_W-1:0] key,
                           logic [lfu_pkg::VAL_W-1:0] val);
    start          <= 1'b1;
    in_cmd         <= cmd;
    in_lookup_key  <= key;
    in_write_value <= val;
    do @(posedge clk); while (busy);
    pending_results.push_back(cache_access(cmd, key, val));
    items_sent++;
  endtask

  // sender bursts: random gaps between runs of back-to-back items
  task automatic sender_gap();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    burst_left = $urandom_range(0, 12);
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // capacity write with the block idle
  task automatic write_capacity(logic [lfu_pkg::CAP_W-1:0] cap);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= cap;
    @(posedge clk);
    cfg_we <= 1'b0;
    sh_cap = cap;
  endtask

  // compare each result against the oldest expectation
  always @(posedge clk) begin
    lookup_result_t exp_r;
    if (rst_n && out_valid) begin
      results_seen++;
      if (out_hit) hits_seen++;
      if (out_evicted) evictions_seen++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result hit=%0b", $time, out_hit);
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        if (out_hit !== exp_r.hit) begin
          $display("%0t: hit exp %0b got %0b", $time, exp_r.hit, out_hit);
          errors++;
        end
        if (out_read_value !== exp_r.read_value) begin
          $display("%0t: read_value exp %h got %h", $time, exp_r.read_value, out_read_value);
          errors++;
        end
        if (out_evicted !== exp_r.evicted) begin
          $display("%0t: evicted exp %0b got %0b", $time, exp_r.evicted, out_evicted);
          errors++;
        end
        if (out_evicted_key !== exp_r.evicted_key) begin
          $display("%0t: evicted_key exp %h got %h", $time, exp_r.evicted_key,
                   out_evicted_key);
          errors++;
        end
      end
    end
  end

  // edges of the fields, fill to capacity, LFU and LRU eviction order
  task automatic test_directed_fill();
    send_item(lfu_pkg::CMD_GET, 32'h0, 32'h0);
    send_item(lfu_pkg::CMD_PUT, 32'h0, 32'hFFFF_FFFF);
    send_item(lfu_pkg::CMD_PUT, 32'hFFFF_FFFF, 32'h0);
    send_item(lfu_pkg::CMD_GET, 32'h0, 32'h1234_5678);
    send_item(lfu_pkg::CMD_GET, 32'hFFFF_FFFF, 32'h0);
    send_item(lfu_pkg::CMD_PUT, 32'h0, 32'hA5A5_5A5A);
    send_item(lfu_pkg::CMD_GET, 32'h0, 32'h0);
    for (int i = 1; i <= 14; i++) send_item(lfu_pkg::CMD_PUT, 32'h100 + i, 32'h5000 + i);
    // table full: next puts evict count-1 entries, oldest first
    send_item(lfu_pkg::CMD_PUT, 32'h8000_0000, 32'h1);
    send_item(lfu_pkg::CMD_PUT, 32'h7FFF_FFFF, 32'h2);
    send_item(lfu_pkg::CMD_GET, 32'h101, 32'h0);
  endtask

  // capacity lowered below occupancy, then zero and out-of-range codes
  task automatic test_capacity_extremes();
    write_capacity(5'd2);
    send_item(lfu_pkg::CMD_PUT, 32'hDEAD_BEEF, 32'h3);
    send_item(lfu_pkg::CMD_PUT, 32'hCAFE_0001, 32'h4);
    write_capacity(5'd0);
    send_item(lfu_pkg::CMD_PUT, 32'h0000_0042, 32'h5);
    send_item(lfu_pkg::CMD_GET, 32'hDEAD_BEEF, 32'h0);
    write_capacity(5'd31);
    send_item(lfu_pkg::CMD_PUT, 32'h0000_0043, 32'h6);
  endtask

  // random items mostly over a small key pool so hits and evictions are common
  task automatic test_random(int n_items, logic [lfu_pkg::CAP_W-1:0] cap);
    logic [lfu_pkg::KEY_W-1:0] key;
    write_capacity(cap);
    burst_left = 0;
    for (int n = 0; n < n_items; n++) begin
      if (key_pool.size() < 4 || $urandom_range(0, 15) == 0) begin
        key_pool.push_back($urandom());
        if (key_pool.size() > 24) key_pool.delete($urandom_range(0, 23));
      end
      if ($urandom_range(0, 9) == 0) key = $urandom();
      else key = key_pool[$urandom_range(0, key_pool.size() - 1)];
      send_item(logic'($urandom_range(0, 1)), key, $urandom());
      sender_gap();
    end
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_cmd = lfu_pkg::CMD_GET;
    in_lookup_key = '0;
    in_write_value = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    errors = 0;
    items_sent = 0;
    results_seen = 0;
    hits_seen = 0;
    evictions_seen = 0;
    burst_left = 0;
    sh_cap = 5'd16;
    sh_occ = 0;
    for (int i = 0; i < lfu_pkg::ENTRIES; i++) begin
      sh_valid[i] = 1'b0;
      sh_key[i] = '0;
      sh_data[i] = '0;
      sh_count[i] = '0;
      sh_age[i] = 0;
    end
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_fill();
    test_capacity_extremes();
    test_random(150, 5'd16);
    test_random(150, 5'd3);
    test_random(120, 5'd1);
    test_random(100, 5'd0);
    test_random(130, 5'd8);
    test_random(100, 5'd31);

    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    $display("Sent %0d items, checked %0d results (%0d hits, %0d evictions)",
             items_sent, results_seen, hits_seen, evictions_seen);
    $display("Capacities 16, 2, 0, 31, 3, 1 and 8 exercised; %0d mismatches", errors);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // overall time limit
  initial begin
    #2000000;
    $display("Timeout with %0d results outstanding", pending_results.size());
    $display("FAIL");
    $finish;
  end
endmodule

@@ sim.f @@
rtl/lfu_pkg.sv
rtl/lfu_ram.sv
rtl/lfu_cache_table.sv
dv/tb_lfu_cache_table.sv
